// ----- src/atcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_pkg
// shared types, character codes and the command pattern table
// ----------------------------------------------------------------------------
package atcl_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_BS,
    OP_CR
  } op_t;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [6:0] CHAR_UC_A  = 7'd65;
  localparam logic [6:0] CHAR_UC_Z  = 7'd90;
  localparam logic [6:0] CASE_DIFF  = 7'd32;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam logic [4:0] CMD_EMPTY   = 5'd0;
  localparam logic [4:0] CMD_ATE0    = 5'd1;
  localparam logic [4:0] CMD_ATE1    = 5'd10;
  localparam logic [4:0] CMD_UNKNOWN = 5'd16;

  localparam logic [1:0] STEP_FIRST = 2'd0;
  localparam logic [1:0] STEP_MID   = 2'd1;
  localparam logic [1:0] STEP_LAST  = 2'd2;

  localparam int NUM_PAT    = 15;
  localparam int PAT_MAXLEN = 14;
  localparam int PAT_BITS   = PAT_MAXLEN * 8;

  // text right-justified, first character in the highest used byte
  localparam logic [PAT_BITS-1:0] PAT_STR [NUM_PAT] = '{
    PAT_BITS'("ate0"),
    PAT_BITS'("at"),
    PAT_BITS'("atd"),
    PAT_BITS'("at+cwjap="),
    PAT_BITS'("at+rfpower="),
    PAT_BITS'("ath"),
    PAT_BITS'("at+locale="),
    PAT_BITS'("at+time?"),
    PAT_BITS'("at+wget"),
    PAT_BITS'("ate1"),
    PAT_BITS'("+++"),
    PAT_BITS'("at+msxrc2014"),
    PAT_BITS'("at+freememory?"),
    PAT_BITS'("at+reset"),
    PAT_BITS'("at+baud=")
  };

  localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
    4'd4, 4'd2, 4'd3, 4'd9, 4'd11, 4'd3, 4'd10, 4'd8,
    4'd7, 4'd4, 4'd3, 4'd12, 4'd14, 4'd8, 4'd8
  };

  // bit k set: pattern k matches as a prefix
  localparam logic [NUM_PAT-1:0] PAT_PREFIX = 15'b100_0001_0101_1100;

  function automatic logic [6:0] pat_char(input int k, input logic [3:0] i);
    logic [PAT_BITS-1:0] s;
    int                  pos;
    s   = PAT_STR[k];
    pos = int'(PAT_LEN[k]) - 1 - int'(i);
    if (pos < 0) begin
      return 7'd0;
    end
    return s[pos*8 +: 7];
  endfunction

  function automatic logic [6:0] fold_lower(input logic [6:0] c);
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      return c + CASE_DIFF;
    end
    return c;
  endfunction

endpackage

// ----- src/at_command_line_recognizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_line_recognizer
// line editor with echo; on carriage return the stored line is compared
// against the command table one character per cycle
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  in       | in_valid, in_ready, in_byte                  | sink
//  out      | out_valid, out_ready, out_kind, out_byte,    | source
//           | out_command, out_last                        |
//
//  printable byte: one echo transaction when echo is on and the line is not full
//  backspace: three echo transactions when echo is on
//  carriage return: the first min(length,14) characters are compared, the line is
//  decided, then up to three result transactions
//  reset clears length, echo (to on) and control; the line memory is not cleared
//  a stalled output holds the sequencer; in_ready only in the idle state
module at_command_line_recognizer #(
  parameter int LINE_MAX = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic [4:0] out_command,
  output logic       out_last
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int NP = atcl_pkg::NUM_PAT;

  atcl_pkg::state_t state_r, state_nxt;
  atcl_pkg::op_t    op_r, op_nxt;

  logic [LW-1:0] len_r, len_nxt;
  logic          echo_r, echo_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [3:0]    cmp_i_r, cmp_i_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [NP-1:0] alive_r, alive_nxt;
  logic [4:0]    code_r, code_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [4:0]    out_command_r, out_command_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_fire;
  logic          is_cr, is_bs, is_print, line_full;
  logic [3:0]    scan_n;
  logic          issue, scan_done, emit_fire;
  logic          ram_we;
  logic [6:0]    ram_rdata, ch;
  logic [NP-1:0] match;
  logic [4:0]    code_dec;

  atcl_ram #(
    .WIDTH (7),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_byte[6:0]),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == atcl_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_cr     = (in_byte == atcl_pkg::CHAR_CR);
  assign is_bs     = (in_byte == atcl_pkg::CHAR_BS);
  assign is_print  = (in_byte >= atcl_pkg::CHAR_SPACE) && (in_byte < atcl_pkg::CHAR_DEL);
  assign line_full = (len_r == LW'(LINE_MAX));
  assign scan_n    = (len_r < LW'(atcl_pkg::PAT_MAXLEN)) ? len_r[3:0]
                                                         : 4'(atcl_pkg::PAT_MAXLEN);
  assign issue     = (state_r == atcl_pkg::ST_SCAN) && (idx_r < scan_n);
  assign scan_done = (state_r == atcl_pkg::ST_SCAN) && !issue && !cmp_v_r;
  assign emit_fire = (state_r == atcl_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign ch        = atcl_pkg::fold_lower(ram_rdata);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atcl_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (is_cr) begin
            state_nxt = atcl_pkg::ST_SCAN;
          end else if (is_bs && echo_r) begin
            state_nxt = atcl_pkg::ST_EMIT;
          end else if (is_print && !line_full && echo_r) begin
            state_nxt = atcl_pkg::ST_EMIT;
          end else begin
            state_nxt = atcl_pkg::ST_IDLE;
          end
        end
      end
      atcl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = atcl_pkg::ST_DECIDE;
        end
      end
      atcl_pkg::ST_DECIDE: begin
        state_nxt = atcl_pkg::ST_EMIT;
      end
      atcl_pkg::ST_EMIT: begin
        if (emit_fire && step_r == atcl_pkg::STEP_LAST) begin
          state_nxt = atcl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = atcl_pkg::ST_IDLE;
    endcase
  end

  // pattern match decision
  always_comb begin
    code_dec = atcl_pkg::CMD_UNKNOWN;
    for (int k = 0; k < NP; k++) begin
      if (atcl_pkg::PAT_PREFIX[k]) begin
        match[k] = alive_r[k] && (len_r >= LW'(atcl_pkg::PAT_LEN[k]));
      end else begin
        match[k] = alive_r[k] && (len_r == LW'(atcl_pkg::PAT_LEN[k]));
      end
    end
    for (int k = NP - 1; k >= 0; k--) begin
      if (match[k]) begin
        code_dec = 5'(k + 1);
      end
    end
    if (len_r == '0) begin
      code_dec = atcl_pkg::CMD_EMPTY;
    end
  end

  // sequencer outputs and datapath
  always_comb begin
    op_nxt          = op_r;
    len_nxt         = len_r;
    echo_nxt        = echo_r;
    byte_nxt        = byte_r;
    step_nxt        = step_r;
    idx_nxt         = idx_r;
    cmp_i_nxt       = cmp_i_r;
    cmp_v_nxt       = 1'b0;
    alive_nxt       = alive_r;
    code_nxt        = code_r;
    ram_we          = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_byte_nxt    = out_byte_r;
    out_command_nxt = out_command_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      atcl_pkg::ST_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_byte;
          if (is_cr) begin
            op_nxt    = atcl_pkg::OP_CR;
            idx_nxt   = '0;
            alive_nxt = '1;
          end else if (is_bs) begin
            op_nxt   = atcl_pkg::OP_BS;
            step_nxt = atcl_pkg::STEP_FIRST;
            if (len_r != '0) begin
              len_nxt = len_r - LW'(1);
            end
          end else if (is_print && !line_full) begin
            op_nxt   = atcl_pkg::OP_PRINT;
            step_nxt = atcl_pkg::STEP_LAST;
            ram_we   = 1'b1;
            len_nxt  = len_r + LW'(1);
          end
        end
      end
      atcl_pkg::ST_SCAN: begin
        if (issue) begin
          idx_nxt   = idx_r + 4'd1;
          cmp_i_nxt = idx_r;
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r) begin
          for (int k = 0; k < NP; k++) begin
            if (cmp_i_r < atcl_pkg::PAT_LEN[k] && ch != atcl_pkg::pat_char(k, cmp_i_r)) begin
              alive_nxt[k] = 1'b0;
            end
          end
        end
      end
      atcl_pkg::ST_DECIDE: begin
        code_nxt = code_dec;
        len_nxt  = '0;
        step_nxt = echo_r ? atcl_pkg::STEP_FIRST : atcl_pkg::STEP_LAST;
        if (code_dec == atcl_pkg::CMD_ATE0) begin
          echo_nxt = 1'b0;
        end else if (code_dec == atcl_pkg::CMD_ATE1) begin
          echo_nxt = 1'b1;
        end
      end
      atcl_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = atcl_pkg::KIND_ECHO;
          out_command_nxt = atcl_pkg::CMD_EMPTY;
          out_last_nxt    = (step_r == atcl_pkg::STEP_LAST);
          step_nxt        = step_r + 2'd1;
          unique case (op_r)
            atcl_pkg::OP_PRINT: out_byte_nxt = byte_r;
            atcl_pkg::OP_BS: begin
              out_byte_nxt = (step_r == atcl_pkg::STEP_MID) ? atcl_pkg::CHAR_SPACE
                                                            : atcl_pkg::CHAR_BS;
            end
            atcl_pkg::OP_CR: begin
              priority case (step_r)
                atcl_pkg::STEP_FIRST: out_byte_nxt = atcl_pkg::CHAR_CR;
                atcl_pkg::STEP_MID:   out_byte_nxt = atcl_pkg::CHAR_LF;
                default: begin
                  out_byte_nxt    = 8'd0;
                  out_kind_nxt    = atcl_pkg::KIND_CMD;
                  out_command_nxt = code_r;
                end
              endcase
            end
            default: out_byte_nxt = byte_r;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atcl_pkg::ST_IDLE;
      op_r        <= atcl_pkg::OP_CR;
      len_r       <= '0;
      echo_r      <= 1'b1;
      step_r      <= atcl_pkg::STEP_FIRST;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      len_r       <= len_nxt;
      echo_r      <= echo_nxt;
      step_r      <= step_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    idx_r         <= idx_nxt;
    cmp_i_r       <= cmp_i_nxt;
    alive_r       <= alive_nxt;
    code_r        <= code_nxt;
    out_kind_r    <= out_kind_nxt;
    out_byte_r    <= out_byte_nxt;
    out_command_r <= out_command_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_byte    = out_byte_r;
  assign out_command = out_command_r;
  assign out_last    = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LINE_MAX))
    else $error("line length beyond capacity");

  a_cmd_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == atcl_pkg::KIND_CMD |-> out_last_r)
    else $error("command result not marked last");

  a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atcl_pkg::ST_DECIDE |=> len_r == '0 && state_r == atcl_pkg::ST_EMIT)
    else $error("line not cleared after decision");

  a_ate0_echo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atcl_pkg::ST_DECIDE && code_dec == atcl_pkg::CMD_ATE0 |=> !echo_r)
    else $error("echo not switched off");

endmodule

// ----- src/atcl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module atcl_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the AT command line recogniser and checks every
// echo and command transaction against a behavioural model of the line
// editor and command matcher.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINE_LIMIT = 64;
  localparam int NUM_CMDS   = 15;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [4:0] cmd;
    logic       last;
  } out_txn_t;

  // command texts in match order, code is index + 1
  string cmd_text [NUM_CMDS] = '{
    "ate0", "at", "atd", "at+cwjap=", "at+rfpower=", "ath", "at+locale=",
    "at+time?", "at+wget", "ate1", "+++", "at+msxrc2014", "at+freememory?",
    "at+reset", "at+baud="
  };
  localparam bit [NUM_CMDS-1:0] PREFIX_MASK = 15'b100_0001_0101_1100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [4:0] out_command;
  logic       out_last;

  logic [7:0] tx_bytes [$];
  out_txn_t   expected_out [$];
  int         counted = 0;
  int         errors = 0;
  int         rx_count = 0;

  // line editor model
  logic [6:0] line_chars [LINE_LIMIT];
  int         line_len = 0;
  bit         echo_en = 1'b1;

  // driver state
  int burst_left = 8;
  int gap_left = 0;

  // receiver state
  int         hold_left = 0;
  bit         held = 1'b0;
  int         mode = 0;
  int         mode_left = 30;
  logic [7:0] stall_pat = 8'b1011_0110;

  at_command_line_recognizer #(
    .LINE_MAX(LINE_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_command(out_command),
    .out_last   (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_printable(input logic [7:0] b);
    return b >= atcl_pkg::CHAR_SPACE && b < atcl_pkg::CHAR_DEL;
  endfunction

  function automatic logic [4:0] classify_line();
    int         k;
    int         i;
    int         len;
    bit         hit;
    logic [6:0] ch;
    logic [7:0] pc;
    if (line_len == 0) begin
      return atcl_pkg::CMD_EMPTY;
    end
    for (k = 0; k < NUM_CMDS; k++) begin
      len = cmd_text[k].len();
      hit = PREFIX_MASK[k] ? (line_len >= len) : (line_len == len);
      for (i = 0; i < len && hit; i++) begin
        ch = line_chars[i];
        if (ch >= atcl_pkg::CHAR_UC_A && ch <= atcl_pkg::CHAR_UC_Z) begin
          ch = ch + atcl_pkg::CASE_DIFF;
        end
        pc = cmd_text[k][i];
        if (ch != pc[6:0]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        return 5'(k + 1);
      end
    end
    return atcl_pkg::CMD_UNKNOWN;
  endfunction

  task automatic model_byte(input logic [7:0] b);
    out_txn_t   res [3];
    int         n;
    int         i;
    logic [4:0] code;
    n = 0;
    if (b == atcl_pkg::CHAR_CR) begin
      code = classify_line();
      if (echo_en) begin
        res[n] = '{atcl_pkg::KIND_ECHO, atcl_pkg::CHAR_CR, '0, 1'b0};
        n++;
        res[n] = '{atcl_pkg::KIND_ECHO, atcl_pkg::CHAR_LF, '0, 1'b0};
        n++;
      end
      res[n] = '{atcl_pkg::KIND_CMD, 8'd0, code, 1'b0};
      n++;
      if (code == atcl_pkg::CMD_ATE0) begin
        echo_en = 1'b0;
      end else if (code == atcl_pkg::CMD_ATE1) begin
        echo_en = 1'b1;
      end
      line_len = 0;
    end else if (b == atcl_pkg::CHAR_BS) begin
      if (line_len > 0) begin
        line_len--;
      end
      if (echo_en) begin
        res[0] = '{atcl_pkg::KIND_ECHO, atcl_pkg::CHAR_BS, '0, 1'b0};
        res[1] = '{atcl_pkg::KIND_ECHO, atcl_pkg::CHAR_SPACE, '0, 1'b0};
        res[2] = '{atcl_pkg::KIND_ECHO, atcl_pkg::CHAR_BS, '0, 1'b0};
        n = 3;
      end
    end else if (is_printable(b) && line_len < LINE_LIMIT) begin
      line_chars[line_len] = b[6:0];
      line_len++;
      if (echo_en) begin
        res[0] = '{atcl_pkg::KIND_ECHO, b, '0, 1'b0};
        n = 1;
      end
    end
    for (i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      expected_out.push_back(res[i]);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    if (b == atcl_pkg::CHAR_CR || b == atcl_pkg::CHAR_BS || is_printable(b)) begin
      counted++;
    end
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      queue_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(atcl_pkg::CHAR_SPACE, atcl_pkg::CHAR_DEL - 1));
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        model_byte(in_byte);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_byte  <= tx_bytes.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 80);
        stall_pat <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held && rx_count >= 30) begin
        held      <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= stall_pat[0];
          end
          default: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_txn_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_count <= rx_count + 1;
      if (expected_out.size() == 0) begin
        $error("unexpected transaction: out_kind %0d out_byte %0d out_command %0d",
               out_kind, out_byte, out_command);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0d, got %0d", want.data, out_byte);
          errors++;
        end
        if (out_command !== want.cmd) begin
          $error("out_command: expected %0d, got %0d", want.cmd, out_command);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int         k;
    int         i;
    int         j;
    int         n;
    int         sel;
    bit         typo;
    logic [7:0] c;

    // extremes, ignored bytes, backspace on empty, unknown and empty lines
    queue_byte(8'd0);
    queue_byte(8'd255);
    queue_byte(atcl_pkg::CHAR_DEL);
    queue_byte(atcl_pkg::CHAR_BS);
    queue_byte(atcl_pkg::CHAR_CR);
    queue_byte(atcl_pkg::CHAR_SPACE);
    queue_byte(8'd126);
    queue_byte(atcl_pkg::CHAR_CR);
    // echo off, command with echo off, echo back on
    queue_text("ATE0");
    queue_byte(atcl_pkg::CHAR_CR);
    queue_text("aT");
    queue_byte(atcl_pkg::CHAR_BS);
    queue_text("T");
    queue_byte(atcl_pkg::CHAR_CR);
    queue_text("ate1");
    queue_byte(atcl_pkg::CHAR_CR);

    // full line: prefix command padded past the line limit
    queue_text("atd");
    for (i = 3; i < LINE_LIMIT + 3; i++) begin
      queue_byte(rand_printable());
    end
    queue_byte(atcl_pkg::CHAR_CR);

    while (counted < 100) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        k    = $urandom_range(0, NUM_CMDS - 1);
        typo = ($urandom_range(0, 3) == 0);
        j    = $urandom_range(0, cmd_text[k].len());
        for (i = 0; i <= cmd_text[k].len(); i++) begin
          if (typo && i == j) begin
            queue_byte(rand_printable());
            queue_byte(atcl_pkg::CHAR_BS);
          end
          if (i < cmd_text[k].len()) begin
            c = cmd_text[k][i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
              c = c - atcl_pkg::CASE_DIFF;
            end
            queue_byte(c);
          end
        end
        if (PREFIX_MASK[k]) begin
          n = $urandom_range(0, 5);
          for (i = 0; i < n; i++) begin
            queue_byte(rand_printable());
          end
        end
        queue_byte(atcl_pkg::CHAR_CR);
      end else if (sel < 72) begin
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
          queue_byte(($urandom_range(0, 5) == 0) ? atcl_pkg::CHAR_BS : rand_printable());
        end
        queue_byte(atcl_pkg::CHAR_CR);
      end else if (sel < 84) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          queue_byte(8'($urandom));
        end
      end else if (sel < 92) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          queue_byte(atcl_pkg::CHAR_BS);
        end
        queue_byte(atcl_pkg::CHAR_CR);
      end else begin
        // exact command with a trailing character
        k = $urandom_range(0, NUM_CMDS - 1);
        queue_text(cmd_text[k]);
        queue_byte(rand_printable());
        queue_byte(atcl_pkg::CHAR_CR);
      end
    end

    while (tx_bytes.size() != 0 || in_valid || expected_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
